// ===== hw/rtl/lpmd_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpmd_pkg: shared types for the length-prefixed message deframer
// result record and field widths used by the core, the output stage and top
// ---------------------------------------------------------------------------
package lpmd_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned FIELD_W   = 16;
	localparam int unsigned LEN_W     = 32;
	localparam int unsigned HDR_CNT_W = 4;
	localparam int unsigned HDR_W     = 4 * FIELD_W;
	localparam int unsigned TDATA_W   = 4 * FIELD_W + 2 * LEN_W + BYTE_W;

	// header byte positions
	localparam logic [HDR_CNT_W-1:0] HDR_WORD_BYTES = HDR_CNT_W'(8);
	localparam logic [HDR_CNT_W-1:0] HDR_LAST_BYTE  = HDR_CNT_W'(11);

	typedef enum logic {
		KIND_HEADER  = 1'b0,
		KIND_PAYLOAD = 1'b1
	} lpmd_kind_t;

	typedef struct packed {
		lpmd_kind_t          item_kind;
		logic [FIELD_W-1:0]  msg_type;
		logic [FIELD_W-1:0]  command;
		logic [FIELD_W-1:0]  seq_index;
		logic [FIELD_W-1:0]  total_count;
		logic [LEN_W-1:0]    payload_length;
		logic [BYTE_W-1:0]   data_byte;
		logic [LEN_W-1:0]    byte_offset;
		logic                last;
	} lpmd_res_t;

endpackage

// ===== hw/rtl/lpmd_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpmd_core: header gather and payload tracking
// updates framing state per accepted byte and forms the matching result
// ---------------------------------------------------------------------------
module lpmd_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [lpmd_pkg::BYTE_W-1:0] in_byte,
	input  logic                       restart,
	output logic                       res_valid,
	output lpmd_pkg::lpmd_res_t        res
);
	import lpmd_pkg::*;

	logic                 in_payload_q;
	logic [HDR_CNT_W-1:0] hdr_cnt_q;
	logic [HDR_W-1:0]     hdr_words_q;
	logic [LEN_W-1:0]     len_q;
	logic [LEN_W-1:0]     remaining_q;
	logic [LEN_W-1:0]     offset_q;

	logic [LEN_W-1:0]     len_next;
	logic                 hdr_done;

	assign len_next = {len_q[LEN_W-BYTE_W-1:0], in_byte};
	// a counter past the last position counts as the final header byte
	assign hdr_done = (hdr_cnt_q >= HDR_LAST_BYTE);

	always_comb begin
		res.item_kind      = KIND_HEADER;
		res.msg_type       = hdr_words_q[4*FIELD_W-1:3*FIELD_W];
		res.command        = hdr_words_q[3*FIELD_W-1:2*FIELD_W];
		res.seq_index      = hdr_words_q[2*FIELD_W-1:FIELD_W];
		res.total_count    = hdr_words_q[FIELD_W-1:0];
		res.payload_length = len_next;
		res.data_byte      = '0;
		res.byte_offset    = '0;
		res.last           = (len_next == '0);
		res_valid          = 1'b0;
		if (!restart) begin
			if (in_payload_q) begin
				res_valid          = 1'b1;
				res.item_kind      = KIND_PAYLOAD;
				res.payload_length = len_q;
				res.data_byte      = in_byte;
				res.byte_offset    = offset_q;
				res.last           = (remaining_q == LEN_W'(1));
			end else begin
				res_valid = hdr_done;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q <= 1'b0;
			hdr_cnt_q    <= '0;
			hdr_words_q  <= '0;
			len_q        <= '0;
			remaining_q  <= '0;
			offset_q     <= '0;
		end else if (accept) begin
			if (restart) begin
				in_payload_q <= 1'b0;
				hdr_cnt_q    <= '0;
				hdr_words_q  <= '0;
				len_q        <= '0;
				remaining_q  <= '0;
				offset_q     <= '0;
			end else if (in_payload_q) begin
				remaining_q <= remaining_q - LEN_W'(1);
				offset_q    <= offset_q + LEN_W'(1);
				if (remaining_q == LEN_W'(1)) begin
					in_payload_q <= 1'b0;
					hdr_cnt_q    <= '0;
				end
			end else if (hdr_cnt_q < HDR_WORD_BYTES) begin
				hdr_words_q <= {hdr_words_q[HDR_W-BYTE_W-1:0], in_byte};
				hdr_cnt_q   <= hdr_cnt_q + HDR_CNT_W'(1);
			end else begin
				len_q <= len_next;
				if (!hdr_done) begin
					hdr_cnt_q <= hdr_cnt_q + HDR_CNT_W'(1);
				end else begin
					hdr_cnt_q    <= '0;
					remaining_q  <= len_next;
					offset_q     <= '0;
					in_payload_q <= (len_next != '0);
				end
			end
		end
	end

endmodule

// ===== hw/rtl/lpmd_oreg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpmd_oreg: result register
// holds one result until taken; refills in the cycle it drains
// ---------------------------------------------------------------------------
module lpmd_oreg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  logic                load_valid,
	input  lpmd_pkg::lpmd_res_t load_res,
	output logic                can_load,
	output logic                out_valid,
	input  logic                out_ready,
	output lpmd_pkg::lpmd_res_t out_res
);
	import lpmd_pkg::*;

	logic      valid_q;
	lpmd_res_t res_q;

	assign can_load  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= load_valid;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && load_valid) begin
			res_q <= load_res;
		end
	end

endmodule

// ===== hw/rtl/length_prefixed_message_deframer.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// length_prefixed_message_deframer: byte stream to header and payload records
// splits a stream into 12-byte big-endian headers and their payloads
// ---------------------------------------------------------------------------
// usage
//   s_axis carries one stream byte per request; tuser high means restart:
//   the byte is dropped and any partial message is discarded
//   m_axis gives one record per completed header and per payload byte;
//   tuser is the kind (0 header, 1 payload byte), tlast marks message end
//   a header with zero length comes out with tlast set and no payload
// throughput
//   one input byte per clock while the receiver keeps m_axis_tready high; a new
//   byte is taken while the previous record still sits in the result register,
//   as long as the receiver drains it in the same cycle
// output
//   a record is registered and appears in the cycle after the byte that completes it
// reset
//   arst_n clears framing state and the result valid flag; the block then
//   waits for the first header byte
// stall
//   while the result register is full and m_axis_tready is low, tready on
//   s_axis drops; nothing is lost and the held record stays stable
// ---------------------------------------------------------------------------
module length_prefixed_message_deframer (
	input  logic                         clk,
	input  logic                         arst_n,
	// input stream
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [lpmd_pkg::BYTE_W-1:0]  s_axis_tdata,  // in_byte
	input  logic                         s_axis_tuser,  // restart
	// result stream
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// msg_type, command, seq_index, total_count, payload_length, data_byte,
	// byte_offset (from bit 0 up)
	output logic [lpmd_pkg::TDATA_W-1:0] m_axis_tdata,
	output logic                         m_axis_tuser,  // item_kind
	output logic                         m_axis_tlast   // last
);
	import lpmd_pkg::*;

	logic      accept;
	logic      core_valid;
	lpmd_res_t core_res;
	lpmd_res_t out_res;

	// a byte goes in whenever the result register can take its outcome
	assign accept = s_axis_tvalid && s_axis_tready;

	lpmd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_byte   (s_axis_tdata),
		.restart   (s_axis_tuser),
		.res_valid (core_valid),
		.res       (core_res)
	);

	lpmd_oreg u_oreg (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (accept),
		.load_valid (core_valid),
		.load_res   (core_res),
		.can_load   (s_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_res    (out_res)
	);

	// pack record fields, first field in the low bits
	assign m_axis_tdata = {out_res.byte_offset, out_res.data_byte, out_res.payload_length,
		out_res.total_count, out_res.seq_index, out_res.command, out_res.msg_type};
	assign m_axis_tuser = out_res.item_kind;
	assign m_axis_tlast = out_res.last;

endmodule
